FILE: design/itar_pkg.sv
// ----------------------------------------------------------------------------
// itar_pkg: shared definitions for the integer to ascii converter
// constants, character mapping and the controller/datapath interface types
// ----------------------------------------------------------------------------
package itar_pkg;

    // fixed field widths
    localparam int NUMBER_W       = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 6;

    // default operand width
    localparam int VALUE_BITS_DEF = 32;

    // register reset and legal base range
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // special characters
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] ALPHA_CHAR = 8'h61;
    localparam logic [DIGIT_W-1:0] TEN       = 6'd10;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // take a new number, clear division state
        logic div_step;   // one restoring division bit
        logic digit_wr;   // store remainder, bump digit count, restart division
        logic out_sign;   // load '-' into the output register
        logic out_digit;  // load the read digit, count down
        logic out_bad;    // load the invalid base marker
    } itar_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic radix_bad;  // configured base outside the legal range
        logic bit_last;   // final bit of the current division
        logic q_zero;     // quotient is zero
        logic cnt_max;    // digit store about to be full
        logic neg;        // number was negative
        logic out_last;   // output register holds the final character
    } itar_sts_t;

    // digit value to lower-case ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < TEN)
        begin
            c = ZERO_CHAR + {2'b00, d};
        end
        else
        begin
            c = ALPHA_CHAR + {2'b00, d - TEN};
        end
        return c;
    endfunction

endpackage

FILE: design/itar_ram.sv
// ----------------------------------------------------------------------------
// itar_ram: generic single write port ram
// one write and one read address per cycle, registered read data
// ----------------------------------------------------------------------------
module itar_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/itar_dp.sv
// ----------------------------------------------------------------------------
// itar_dp: conversion datapath
// base register, bit-serial divider, digit store and output register
// ----------------------------------------------------------------------------
module itar_dp
    import itar_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RADIX_W-1:0]  cfg_wdata,
    input  logic [NUMBER_W-1:0] number,
    input  itar_cmd_t           cmd,
    output itar_sts_t           sts,
    output logic [CHAR_W-1:0]   character,
    output logic                last,
    output logic                bad_radix
);

    localparam int BW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);

    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [BW-1:0]         bit_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  neg_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic                  bad_reg;

    logic [NUMBER_W+VALUE_BITS-1:0] num_ext;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W:0]      rem_sh;
    logic [DIGIT_W:0]      rem_sub;
    logic                  rem_ge;
    logic [CW-1:0]         cnt_dec;
    logic [DIGIT_W-1:0]    rd_digit;

    // base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    // operand: low bits of the field, magnitude of the two's complement value
    assign num_ext = {{VALUE_BITS{1'b0}}, number};
    assign raw     = num_ext[VALUE_BITS-1:0];
    assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg, q_reg[VALUE_BITS-1]};
    assign rem_ge   = rem_sh >= {1'b0, radix_reg};
    assign rem_sub  = rem_sh - {1'b0, radix_reg};
    assign rem_next = rem_ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
    assign q_next   = {q_reg[VALUE_BITS-2:0], rem_ge};

    assign cnt_dec = cnt_reg - 1'b1;

    // divider and digit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= '0;
            rem_reg <= '0;
            bit_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                q_reg   <= mag;
                rem_reg <= '0;
                bit_reg <= '0;
                cnt_reg <= '0;
                neg_reg <= raw[VALUE_BITS-1];
            end
            else if (cmd.div_step)
            begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                bit_reg <= bit_reg + 1'b1;
            end
            else if (cmd.digit_wr)
            begin
                rem_reg <= '0;
                bit_reg <= '0;
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.out_digit)
            begin
                cnt_reg <= cnt_dec;
            end
        end
    end

    // digit store, least significant digit first
    itar_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.digit_wr),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (rem_reg),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (rd_digit)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_bad)
        begin
            char_reg <= NUL_CHAR;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
        else if (cmd.out_sign)
        begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end
        else if (cmd.out_digit)
        begin
            char_reg <= digit_char(rd_digit);
            last_reg <= (cnt_reg == CW'(1));
            bad_reg  <= 1'b0;
        end
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;

    // status to the controller
    assign sts.radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    assign sts.bit_last  = (bit_reg == BW'(VALUE_BITS - 1));
    assign sts.q_zero    = (q_reg == '0);
    assign sts.cnt_max   = (cnt_reg == CW'(VALUE_BITS - 1));
    assign sts.neg       = neg_reg;
    assign sts.out_last  = last_reg;

endmodule

FILE: design/itar_ctrl.sv
// ----------------------------------------------------------------------------
// itar_ctrl: conversion sequencer
// steps the divider per digit, then reads the digits back for output
// ----------------------------------------------------------------------------
module itar_ctrl
    import itar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  itar_sts_t sts,
    output itar_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_DIGIT = 7'b0000100,
        ST_SIGN  = 7'b0001000,
        ST_RD    = 7'b0010000,
        ST_LOAD  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } itar_state_t;

    itar_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.radix_bad)
                    begin
                        cmd.out_bad = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.bit_last)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                cmd.digit_wr = 1'b1;
                if (sts.q_zero || sts.cnt_max)
                begin
                    state_next = sts.neg ? ST_SIGN : ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                cmd.out_sign = 1'b1;
                state_next   = ST_OUT;
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.out_digit = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

FILE: design/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: signed integer to ascii text in base 2 to 36
// one number in, its characters out most significant first, '-' leading
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer
//  ---------+----------------------------------+-----------------------------
//  input    | in_valid in_ready number         | in_valid & in_ready
//  output   | out_valid out_ready character    | out_valid & out_ready
//           | last bad_radix                   |
//  config   | cfg_we cfg_wdata                 | cfg_we, no wait
//
// each digit takes a full pass through the bit-serial divider; once all
// digits are stored, the sign and then each digit are put out, subject to
// output stalls. an invalid base gives one character.
// reset is asynchronous and active low and sets the base to 10.
// one number is held at a time; input is taken only when idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix
    import itar_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RADIX_W-1:0]  cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUMBER_W-1:0] number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   character,
    output logic                last,
    output logic                bad_radix
);

    itar_cmd_t cmd;
    itar_sts_t sts;

    // sequencer
    itar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    itar_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .number    (number),
        .cmd       (cmd),
        .sts       (sts),
        .character (character),
        .last      (last),
        .bad_radix (bad_radix)
    );

    // no input taken while a character is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while output pending");

    // an accepted number blocks further input for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a transfer");

    // invalid base marker is a lone nul character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_radix) |-> (last && character == NUL_CHAR))
        else $error("bad base output malformed");

    // the sign never ends the text
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == MINUS_CHAR) |-> !last)
        else $error("sign marked as final character");

endmodule

FILE: tb/sv/integer_to_ascii_radix_checker.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_checker: text predictor and character checker
// watches the config, number and character channels, builds the expected
// text of every accepted number and compares each character transfer
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_checker
    import itar_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RADIX_W-1:0]  cfg_wdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [NUMBER_W-1:0] number,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CHAR_W-1:0]   character,
    input  logic                last,
    input  logic                bad_radix,
    output int                  fail_count,
    output int                  waiting_chars,
    output int                  chars_checked
);

    // one expected character of the text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } text_char_t;

    text_char_t       text_q[$];
    logic [RADIX_W-1:0] base_q;
    int               fails;
    int               seen;

    // digit value to lower-case ascii
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10)
        begin
            c = ZERO_CHAR + CHAR_W'(d);
        end
        else
        begin
            c = ALPHA_CHAR + CHAR_W'(d) - 8'd10;
        end
        return c;
    endfunction

    // append the text of one number in the given base
    function automatic void predict_text(input logic [NUMBER_W-1:0] value,
                                         input logic [RADIX_W-1:0] base);
        logic [NUMBER_W-1:0] mag;
        logic [NUMBER_W-1:0] rem;
        logic [NUMBER_W-1:0] divisor;
        logic [DIGIT_W-1:0]  digits [NUMBER_W];
        logic                neg;
        int                  n;
        text_char_t          t;
        if (base < RADIX_MIN || base > RADIX_MAX)
        begin
            t.ch   = NUL_CHAR;
            t.last = 1'b1;
            t.bad  = 1'b1;
            text_q.push_back(t);
            return;
        end
        // magnitude held unsigned so the most negative value survives
        neg     = value[NUMBER_W-1];
        mag     = neg ? (~value + 1'b1) : value;
        divisor = NUMBER_W'(base);
        n       = 0;
        do
        begin
            rem       = mag % divisor;
            digits[n] = rem[DIGIT_W-1:0];
            mag       = mag / divisor;
            n++;
        end
        while (mag != 0 && n < NUMBER_W);
        if (neg)
        begin
            t.ch   = MINUS_CHAR;
            t.last = 1'b0;
            t.bad  = 1'b0;
            text_q.push_back(t);
        end
        // most significant digit first
        for (int i = n - 1; i >= 0; i--)
        begin
            t.ch   = ascii_of(digits[i]);
            t.last = (i == 0);
            t.bad  = 1'b0;
            text_q.push_back(t);
        end
    endfunction

    // sample every channel at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            base_q = RADIX_RESET;
            text_q.delete();
            fails  = 0;
            seen   = 0;
            fail_count    <= 0;
            waiting_chars <= 0;
            chars_checked <= 0;
        end
        else
        begin
            // character transfer belongs to the oldest number
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                seen++;
                if (text_q.size() == 0)
                begin
                    $error("character 0x%02h arrived with no text pending", character);
                    fails++;
                end
                else
                begin
                    want = text_q.pop_front();
                    if (character !== want.ch)
                    begin
                        $error("character: expected 0x%02h, actual 0x%02h", want.ch, character);
                        fails++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, last);
                        fails++;
                    end
                    if (bad_radix !== want.bad)
                    begin
                        $error("bad_radix: expected %0b, actual %0b", want.bad, bad_radix);
                        fails++;
                    end
                end
            end
            // number transfer uses the base in force before this edge
            if (in_valid === 1'b1 && in_ready === 1'b1)
            begin
                predict_text(number, base_q);
            end
            if (cfg_we === 1'b1)
            begin
                base_q = cfg_wdata;
            end
            fail_count    <= fails;
            waiting_chars <= text_q.size();
            chars_checked <= seen;
        end
    end

endmodule

FILE: tb/sv/integer_to_ascii_radix_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb: testbench top for the integer to ascii converter
// directed extremes in several bases, then random numbers over random bases
// with random gaps on both channels; the checker does all comparison
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;
    import itar_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [RADIX_W-1:0]  cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [NUMBER_W-1:0] number    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAR_W-1:0]   character;
    logic                last;
    logic                bad_radix;

    int fail_count;
    int waiting_chars;
    int chars_checked;

    int numbers_sent  = 0;
    int random_sent   = 0;
    int bases_written = 0;
    int bad_bases     = 0;
    int send_calm     = 0;
    int hold_cnt      = 0;
    int recv_calm     = 0;

    always #2 clk = ~clk;

    integer_to_ascii_radix DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last),
        .bad_radix (bad_radix)
    );

    integer_to_ascii_radix_checker text_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .number        (number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .character     (character),
        .last          (last),
        .bad_radix     (bad_radix),
        .fail_count    (fail_count),
        .waiting_chars (waiting_chars),
        .chars_checked (chars_checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int g;
        if ($urandom_range(0, 9) == 0)
        begin
            g = $urandom_range(10, 80);
        end
        else
        begin
            g = $urandom_range(0, 3);
        end
        return g;
    endfunction

    // base mix: both legal ends, invalid values, and the middle
    function automatic logic [RADIX_W-1:0] pick_base();
        int sel;
        logic [RADIX_W-1:0] b;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            b = RADIX_MIN;
        end
        else if (sel == 1)
        begin
            b = RADIX_MAX;
        end
        else if (sel == 2)
        begin
            b = ($urandom_range(0, 1) == 1) ? RADIX_W'($urandom_range(0, 1))
                                             : RADIX_W'($urandom_range(37, 63));
        end
        else
        begin
            b = RADIX_W'($urandom_range(3, 35));
        end
        return b;
    endfunction

    // numbers of every size, most of them short
    function automatic logic [NUMBER_W-1:0] pick_number();
        int sel;
        logic [NUMBER_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            v = $urandom;
        end
        else if (sel < 6)
        begin
            v = $urandom_range(0, 1000);
        end
        else if (sel == 6)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000 + $urandom_range(0, 3);
                1: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                2: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: v = $urandom_range(0, 3);
            endcase
        end
        else
        begin
            v = $urandom >> $urandom_range(1, 31);
        end
        if (sel >= 3 && sel != 6 && $urandom_range(0, 1) == 1)
        begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // one number transfer, called and returning at a rising edge
    task automatic send_number(input logic [NUMBER_W-1:0] value);
        int gap;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_calm = $urandom_range(5, 15);
            end
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        numbers_sent++;
    endtask

    // base change once the whole text has drained
    task automatic write_radix(input logic [RADIX_W-1:0] base);
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting_chars != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        bases_written++;
        if (base < RADIX_MIN || base > RADIX_MAX)
        begin
            bad_bases++;
        end
    endtask

    // character side backpressure with quiet stretches
    always @(posedge clk)
    begin
        if (rst_n && hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (rst_n)
        begin
            out_ready <= 1'b1;
            if (recv_calm > 0)
            begin
                recv_calm--;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                recv_calm = $urandom_range(50, 400);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                hold_cnt = pick_gap() + 1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base 10 from reset: zero, signs, digit rollover, both extremes
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'd9);
        send_number(32'd10);
        send_number(-32'sd10);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd123456789);

        // base 2: longest texts
        write_radix(RADIX_MIN);
        send_number(32'd0);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'hFFFF_FFFF);
        send_number(32'd5);

        // base 36: highest letter digit
        write_radix(RADIX_MAX);
        send_number(32'd35);
        send_number(32'd36);
        send_number(-32'sd35);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);

        // invalid bases below and above the legal range
        write_radix(6'd0);
        send_number(32'hFFFF_FFFF);
        write_radix(6'd1);
        send_number(32'd7);
        write_radix(6'd37);
        send_number(32'd0);
        write_radix(6'd63);
        send_number(32'h8000_0000);

        // random bases, each with a run of random numbers
        while (random_sent < 170)
        begin
            write_radix(pick_base());
            repeat ($urandom_range(8, 30))
            begin
                send_number(pick_number());
                random_sent++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting_chars != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d numbers over %0d base writes (%0d invalid bases)",
                 numbers_sent, bases_written, bad_bases);
        $display("%0d characters checked, %0d mismatches", chars_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard
    initial
    begin
        #20000000;
        $display("timeout with %0d characters still expected", waiting_chars);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: integer_to_ascii_radix.f
design/itar_pkg.sv
design/itar_ram.sv
design/itar_dp.sv
design/itar_ctrl.sv
design/integer_to_ascii_radix.sv
tb/sv/integer_to_ascii_radix_checker.sv
tb/sv/integer_to_ascii_radix_tb.sv
